/* hdl/rau_pkg.sv */
// Package: payload types, commands, status codes and sequencer states for the rational unit.
package rau_pkg;

   localparam int WORD_BITS = 32;
   localparam int WIDE_BITS = 2 * WORD_BITS;
   localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_GCD = 3'd4,
      CMD_LCM = 3'd5
   } command_type;

   localparam logic [1:0] ORD_LESS    = 2'd0;
   localparam logic [1:0] ORD_EQUAL   = 2'd1;
   localparam logic [1:0] ORD_GREATER = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic signed [31:0] a_num;
      logic [30:0] a_den;
      logic signed [31:0] b_num;
      logic [30:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0] res_den;
      logic [1:0]  order;
      logic [1:0]  status;
   } rsp_type;

   // Operations of the shared multiplier
   typedef enum logic [1:0] {
      MUL_OP_LX,
      MUL_OP_RX,
      MUL_OP_DEN,
      MUL_OP_NUM
   } mul_op_type;

   // Sequencer states
   typedef enum logic [4:0] {
      S_IDLE,
      S_MUL_LX,
      S_MUL_RX,
      S_MUL_DEN,
      S_MUL_NUM,
      S_SETUP,
      S_LCM_GCD,
      S_LCM_DIV,
      S_LCM_MUL,
      S_GCD,
      S_DIV_NUM,
      S_DIV_DEN,
      S_CHECK,
      S_OUT
   } state_type;

   // Control from the sequencer to the divider
   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;

endpackage

/* hdl/rau_gcd.sv */
// Binary gcd of two 64-bit magnitudes, one subtract or shift step per cycle.
module rau_gcd (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rau_pkg::WIDE_BITS-1:0] x_in,
   input  logic [rau_pkg::WIDE_BITS-1:0] y_in,
   output logic                          done,
   output logic [rau_pkg::WIDE_BITS-1:0] result
);
   import rau_pkg::*;

   logic [WIDE_BITS-1:0] x_ff, x_in_nx, y_ff, y_in_nx;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [WIDE_BITS-1:0] res_ff, res_in;

   // Step: strip common twos, then odd-odd subtract
   always_comb begin
      x_in_nx = x_ff;
      y_in_nx = y_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      if (start) begin
         x_in_nx = x_in;
         y_in_nx = y_in;
         k_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff == '0) begin
            res_in  = y_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (y_ff == '0) begin
            res_in  = x_ff << k_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_in_nx = x_ff >> 1;
            y_in_nx = y_ff >> 1;
            k_in    = k_ff + 1'b1;
         end else if (!x_ff[0]) begin
            x_in_nx = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in_nx = y_ff >> 1;
         end else if (x_ff >= y_ff) begin
            x_in_nx = (x_ff - y_ff) >> 1;
         end else begin
            y_in_nx = (y_ff - x_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in_nx;
      y_ff   <= y_in_nx;
      k_ff   <= k_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

   property p_no_done_busy;
      @(posedge clock) disable iff (reset) done_ff |-> !busy_ff;
   endproperty
   a_no_done_busy: assert property (p_no_done_busy) else $error("gcd done while busy");

   property p_start_busy;
      @(posedge clock) disable iff (reset) start |=> busy_ff;
   endproperty
   a_start_busy: assert property (p_start_busy) else $error("gcd not busy after start");

   property p_done_after_busy;
      @(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff);
   endproperty
   a_done_after_busy: assert property (p_done_after_busy) else $error("gcd done from idle");

endmodule

/* hdl/rau_div.sv */
// Restoring divider for 64-bit unsigned values, one quotient bit per cycle.
module rau_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rau_pkg::WIDE_BITS-1:0] dividend,
   input  logic [rau_pkg::WIDE_BITS-1:0] divisor,
   output logic                          done,
   output logic [rau_pkg::WIDE_BITS-1:0] quotient
);
   import rau_pkg::*;

   logic [WIDE_BITS-1:0] q_ff, q_in, d_ff, d_in;
   logic [WIDE_BITS:0]   r_ff, r_in, r_sh;
   logic [CNT_BITS-1:0]  n_ff, n_in;
   logic                 busy_ff, busy_in, done_ff, done_in;

   // Shift in one dividend bit and try the subtract
   always_comb begin
      q_in    = q_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      n_in    = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r_sh    = {r_ff[WIDE_BITS-1:0], q_ff[WIDE_BITS-1]};
      if (start) begin
         q_in    = dividend;
         d_in    = divisor;
         r_in    = '0;
         n_in    = CNT_BITS'(WIDE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (r_sh >= {1'b0, d_ff}) begin
            r_in = r_sh - {1'b0, d_ff};
            q_in = {q_ff[WIDE_BITS-2:0], 1'b1};
         end else begin
            r_in = r_sh;
            q_in = {q_ff[WIDE_BITS-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      d_ff <= d_in;
      r_ff <= r_in;
      n_ff <= n_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   property p_cnt_nonzero;
      @(posedge clock) disable iff (reset) busy_ff |-> n_ff != '0;
   endproperty
   a_cnt_nonzero: assert property (p_cnt_nonzero) else $error("div count ran out");

   property p_done_idle;
      @(posedge clock) disable iff (reset) done_ff |-> !busy_ff;
   endproperty
   a_done_idle: assert property (p_done_idle) else $error("div done while busy");

   property p_rem_bound;
      @(posedge clock) disable iff (reset) busy_ff && !$past(start) |-> r_ff < {1'b0, d_ff};
   endproperty
   a_rem_bound: assert property (p_rem_bound) else $error("div remainder out of range");

endmodule

/* hdl/rau_mul.sv */
// Registered 33x33 signed multiplier shared by the four products of the multiply steps.
module rau_mul (
   input  logic                                 clock,
   input  logic signed [rau_pkg::WORD_BITS:0]   op_a,
   input  logic signed [rau_pkg::WORD_BITS:0]   op_b,
   output logic signed [rau_pkg::WIDE_BITS+1:0] product
);
   import rau_pkg::*;

   logic signed [WIDE_BITS+1:0] prod_ff;

   // Register each product
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule

/* hdl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: sequencer, shared multiplier, gcd and divider.
//
// Usage:
//   Present a command and two rationals on req_ (req_valid, req_data); the item
//   transfers on a clock edge with req_valid high and req_stall low. One result
//   per item appears on rsp_ (rsp_valid, rsp_data) and transfers when rsp_stall
//   is low. The result holds steady while the receiver stalls.
//   The block works on one item at a time: req_stall is high from transfer
//   until the result has transferred, and the sequencer then returns to idle.
//   Steps: multiplier products for the two cross terms, the denominator and
//   the numerator, a setup step, a binary gcd on 64-bit magnitudes, then two
//   divisions by the gcd and a range check. The lcm command on integers first
//   adds a gcd, a division and one product. Error and unused-command items
//   skip the gcd, the divisions and the range check.
//   Reset (synchronous, active high) returns the sequencer to idle, clears the
//   gcd and divider busy flags and drops any result in flight; the datapath
//   registers are not reset.
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;

   localparam logic [WIDE_BITS-1:0] LIM = {{(WIDE_BITS-WORD_BITS+1){1'b0}},
                                           {(WORD_BITS-1){1'b1}}};

   state_type state_ff, state_in;
   req_type   req_ff;
   logic signed [WIDE_BITS+1:0] lx_ff, rx_ff;
   logic [WIDE_BITS-1:0] nmag_ff, nmag_in, den_ff, den_in, g_ff, g_in;
   logic [WIDE_BITS-1:0] lcm_q_ff, lcm_q_in;
   logic neg_ff, neg_in;
   logic [1:0] status_ff, status_in, order_ff, order_in;
   rsp_type rsp_ff;

   // Shared multiplier operand selection
   mul_op_type mul_op;
   logic signed [WORD_BITS:0] m_a, m_b;
   logic signed [WIDE_BITS+1:0] prod;
   logic signed [WORD_BITS:0] an_x, bn_x, ad_x, bd_x;

   assign an_x = {req_ff.a_num[WORD_BITS-1], req_ff.a_num};
   assign bn_x = {req_ff.b_num[WORD_BITS-1], req_ff.b_num};
   assign ad_x = {2'b00, req_ff.a_den};
   assign bd_x = {2'b00, req_ff.b_den};

   always_comb begin
      case (mul_op)
         MUL_OP_LX: begin
            m_a = an_x;
            m_b = bd_x;
         end
         MUL_OP_RX: begin
            m_a = bn_x;
            m_b = ad_x;
         end
         MUL_OP_DEN: begin
            m_a = ad_x;
            m_b = (req_ff.command == CMD_DIV) ? bn_x : bd_x;
         end
         default: begin
            m_a = an_x;
            m_b = (req_ff.command == CMD_DIV) ? bd_x : bn_x;
         end
      endcase
   end

   rau_mul u_mul (.clock(clock), .op_a(m_a), .op_b(m_b), .product(prod));

   // Gcd and divider
   logic                 gcd_start, gcd_done;
   logic [WIDE_BITS-1:0] gcd_x, gcd_y, gcd_res;
   div_ctl_type          div_ctl;
   logic                 div_done;
   logic [WIDE_BITS-1:0] div_a, div_b, div_q;

   rau_gcd u_gcd (.clock(clock), .reset(reset), .start(gcd_start), .x_in(gcd_x),
                  .y_in(gcd_y), .done(gcd_done), .result(gcd_res));
   rau_div u_div (.clock(clock), .reset(reset), .start(div_ctl.start), .dividend(div_a),
                  .divisor(div_b), .done(div_done), .quotient(div_q));

   function automatic logic [WIDE_BITS-1:0] mag(input logic signed [WIDE_BITS+1:0] v);
      logic signed [WIDE_BITS+1:0] t;
      t = v[WIDE_BITS+1] ? -v : v;
      return t[WIDE_BITS-1:0];
   endfunction

   logic signed [WIDE_BITS+1:0] sum_w;
   logic is_int;
   assign sum_w  = (req_ff.command == CMD_SUB) ? lx_ff - rx_ff : lx_ff + rx_ff;
   assign is_int = (req_ff.a_den == 31'd1) && (req_ff.b_den == 31'd1);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_MUL_LX;
         S_MUL_LX:  state_in = S_MUL_RX;
         S_MUL_RX:  state_in = S_MUL_DEN;
         S_MUL_DEN: state_in = S_MUL_NUM;
         S_MUL_NUM: state_in = S_SETUP;
         S_SETUP: begin
            if (status_in != ST_OK || req_ff.command > CMD_LCM) state_in = S_OUT;
            else if (req_ff.command == CMD_LCM && is_int) state_in = S_LCM_GCD;
            else state_in = S_GCD;
         end
         S_LCM_GCD: if (gcd_done) state_in = S_LCM_DIV;
         S_LCM_DIV: if (div_done) state_in = S_LCM_MUL;
         S_LCM_MUL: state_in = S_GCD;
         S_GCD:     if (gcd_done) state_in = S_DIV_NUM;
         S_DIV_NUM: if (div_done) state_in = S_DIV_DEN;
         S_DIV_DEN: if (div_done) state_in = S_CHECK;
         S_CHECK:   state_in = S_OUT;
         S_OUT:     if (!rsp_stall) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Datapath controls and updates
   always_comb begin
      mul_op    = MUL_OP_LX;
      gcd_start = 1'b0;
      gcd_x     = nmag_ff;
      gcd_y     = den_ff;
      div_ctl   = '0;
      div_a     = nmag_ff;
      div_b     = g_ff;
      nmag_in   = nmag_ff;
      den_in    = den_ff;
      g_in      = g_ff;
      lcm_q_in  = lcm_q_ff;
      neg_in    = neg_ff;
      status_in = status_ff;
      order_in  = order_ff;
      case (state_ff)
         S_MUL_LX:  mul_op = MUL_OP_LX;
         S_MUL_RX:  mul_op = MUL_OP_RX;
         S_MUL_DEN: mul_op = MUL_OP_DEN;
         S_MUL_NUM: begin
            mul_op = MUL_OP_NUM;
            den_in = mag(prod);
         end
         S_SETUP: begin
            order_in  = (lx_ff < rx_ff) ? ORD_LESS :
                        (lx_ff == rx_ff) ? ORD_EQUAL : ORD_GREATER;
            status_in = ST_OK;
            neg_in    = req_ff.a_num[WORD_BITS-1] ^ req_ff.b_num[WORD_BITS-1];
            nmag_in   = mag(prod);
            if (req_ff.command > CMD_LCM) begin
               nmag_in = '0;
            end else if (req_ff.a_den == '0 || req_ff.b_den == '0) begin
               status_in = ST_DIV0;
            end else begin
               case (req_ff.command)
                  CMD_ADD, CMD_SUB: begin
                     neg_in  = sum_w[WIDE_BITS+1];
                     nmag_in = mag(sum_w);
                  end
                  CMD_DIV: if (req_ff.b_num == '0) status_in = ST_DIV0;
                  CMD_GCD: begin
                     neg_in = 1'b0;
                     den_in = WIDE_BITS'(1);
                     if (is_int) begin
                        nmag_in = mag((WIDE_BITS+2)'(an_x));
                        g_in    = mag((WIDE_BITS+2)'(bn_x));
                     end else nmag_in = WIDE_BITS'(1);
                  end
                  CMD_LCM: begin
                     if (is_int) begin
                        neg_in  = 1'b0;
                        nmag_in = mag((WIDE_BITS+2)'(an_x));
                        g_in    = mag((WIDE_BITS+2)'(bn_x));
                        den_in  = WIDE_BITS'(1);
                     end
                  end
                  default: ;
               endcase
            end
            // gcd command: gcd of the two magnitudes over 1
            if (status_in == ST_OK && req_ff.command == CMD_GCD && is_int) begin
               nmag_in = mag((WIDE_BITS+2)'(an_x));
               den_in  = mag((WIDE_BITS+2)'(bn_x));
            end
            gcd_start = (state_in == S_GCD) || (state_in == S_LCM_GCD);
            gcd_x     = nmag_in;
            gcd_y     = (req_ff.command == CMD_LCM && is_int) ? g_in : den_in;
         end
         S_LCM_GCD: begin
            if (gcd_done) begin
               div_ctl.start = 1'b1;
               div_a = nmag_ff;
               div_b = (gcd_res == '0) ? WIDE_BITS'(1) : gcd_res;
            end
         end
         S_LCM_DIV: if (div_done) lcm_q_in = div_q;
         S_LCM_MUL: begin
            nmag_in   = lcm_q_ff[WORD_BITS-1:0] * g_ff[WORD_BITS-1:0];
            if (nmag_ff == '0 || g_ff == '0) nmag_in = '0;
            den_in    = WIDE_BITS'(1);
            gcd_start = 1'b1;
            gcd_x     = nmag_in;
            gcd_y     = WIDE_BITS'(1);
         end
         S_GCD: begin
            if (gcd_done) begin
               // gcd command with integers keeps the gcd as the answer
               if (req_ff.command == CMD_GCD && is_int) begin
                  nmag_in = gcd_res;
                  den_in  = WIDE_BITS'(1);
                  g_in    = WIDE_BITS'(1);
               end else begin
                  g_in = (gcd_res == '0) ? WIDE_BITS'(1) : gcd_res;
               end
               div_ctl.start = 1'b1;
               div_a = nmag_in;
               div_b = g_in;
            end
         end
         S_DIV_NUM: begin
            div_ctl.busy = 1'b1;
            if (div_done) begin
               nmag_in       = div_q;
               div_ctl.start = 1'b1;
               div_a         = den_ff;
               div_b         = g_ff;
            end
         end
         S_DIV_DEN: begin
            div_ctl.busy = 1'b1;
            if (div_done) den_in = div_q;
         end
         S_CHECK: begin
            if (nmag_ff == '0) neg_in = 1'b0;
            if (nmag_ff > LIM || den_ff > LIM) status_in = ST_OVF;
         end
         default: ;
      endcase
   end

   // Output register contents, taken from the values that the last step settles
   rsp_type rsp_in;
   always_comb begin
      rsp_in         = rsp_ff;
      rsp_in.order   = order_in;
      rsp_in.status  = status_in;
      if (status_in == ST_OK) begin
         rsp_in.res_num = neg_in ? -nmag_in[WORD_BITS-1:0] : nmag_in[WORD_BITS-1:0];
         rsp_in.res_den = den_in[WORD_BITS-2:0];
      end else begin
         rsp_in.res_num = '0;
         rsp_in.res_den = (WORD_BITS-1)'(1);
      end
      if (req_ff.command > CMD_LCM) begin
         rsp_in.res_num = '0;
         rsp_in.res_den = (WORD_BITS-1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_MUL_RX) lx_ff <= prod;
      if (state_ff == S_MUL_DEN) rx_ff <= prod;
      nmag_ff   <= nmag_in;
      den_ff    <= den_in;
      g_ff      <= g_in;
      lcm_q_ff  <= lcm_q_in;
      neg_ff    <= neg_in;
      status_ff <= status_in;
      order_ff  <= order_in;
      if (state_ff != S_OUT) rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   property p_rsp_ok_den;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_data.status == ST_OK |-> rsp_data.res_den != '0;
   endproperty
   a_rsp_ok_den: assert property (p_rsp_ok_den) else $error("zero denominator on ok result");

   property p_idle_after_rsp;
      @(posedge clock) disable iff (reset) rsp_valid && !rsp_stall |=> !rsp_valid;
   endproperty
   a_idle_after_rsp: assert property (p_idle_after_rsp) else $error("result repeated");

   property p_err_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_data.status != ST_OK |-> rsp_data.res_num == '0;
   endproperty
   a_err_zero: assert property (p_err_zero) else $error("nonzero numerator on error");

endmodule

/* dv/testbench.sv */
// Testbench for the rational arithmetic unit: directed and random rationals checked against a predictor.
`timescale 1ns / 1ps

class rau_scoreboard;
   rau_pkg::rsp_type awaited[$];
   int unsigned      mismatches;
   int unsigned      checked;

   static function logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   static function logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // Reduce by the gcd and range-check the result
   static function rau_pkg::rsp_type reduce(bit neg, logic [63:0] nmag, logic [63:0] den,
                                            logic [1:0] ord);
      rau_pkg::rsp_type r;
      logic [63:0]      g;
      logic [63:0]      lim;
      lim = (64'd1 << (rau_pkg::WORD_BITS - 1)) - 64'd1;
      r.order   = ord;
      r.res_num = '0;
      r.res_den = 31'd1;
      if (den == 0) begin
         r.status = rau_pkg::ST_DIV0;
         return r;
      end
      g = gcd64(nmag, den);
      nmag = nmag / g;
      den = den / g;
      if (nmag == 0) neg = 1'b0;
      if (nmag > lim || den > lim) begin
         r.status = rau_pkg::ST_OVF;
         return r;
      end
      r.status  = rau_pkg::ST_OK;
      r.res_num = neg ? -nmag[31:0] : nmag[31:0];
      r.res_den = den[30:0];
      return r;
   endfunction

   // Work out the expected result of one request
   static function rau_pkg::rsp_type predict(rau_pkg::req_type q);
      rau_pkg::rsp_type r;
      longint           an, bn, ad, bd, lx, rx, s;
      logic [63:0]      am, bm, l;
      logic [1:0]       ord;
      bit               sgn;
      an = longint'(q.a_num);
      bn = longint'(q.b_num);
      ad = longint'({1'b0, q.a_den});
      bd = longint'({1'b0, q.b_den});
      lx = an * bd;
      rx = bn * ad;
      ord = lx < rx ? rau_pkg::ORD_LESS : (lx == rx ? rau_pkg::ORD_EQUAL
                                                    : rau_pkg::ORD_GREATER);
      am = magnitude(an);
      bm = magnitude(bn);
      sgn = (an < 0) != (bn < 0);
      r.order = ord;
      r.res_num = '0;
      r.res_den = 31'd1;
      r.status = rau_pkg::ST_OK;
      if (q.command > rau_pkg::CMD_LCM) return r;
      if (ad == 0 || bd == 0) begin
         r.status = rau_pkg::ST_DIV0;
         return r;
      end
      case (q.command)
         rau_pkg::CMD_ADD: begin
            s = lx + rx;
            r = reduce(s < 0, magnitude(s), 64'(ad * bd), ord);
         end
         rau_pkg::CMD_SUB: begin
            s = lx - rx;
            r = reduce(s < 0, magnitude(s), 64'(ad * bd), ord);
         end
         rau_pkg::CMD_MUL: r = reduce(sgn, am * bm, 64'(ad * bd), ord);
         rau_pkg::CMD_DIV: begin
            if (bn == 0) r.status = rau_pkg::ST_DIV0;
            else r = reduce(sgn, am * 64'(bd), 64'(ad) * bm, ord);
         end
         rau_pkg::CMD_GCD: begin
            if (ad == 1 && bd == 1) r = reduce(1'b0, gcd64(am, bm), 64'd1, ord);
            else r = reduce(1'b0, 64'd1, 64'd1, ord);
         end
         default: begin
            if (ad == 1 && bd == 1) begin
               l = 0;
               if (am != 0 && bm != 0) l = (am / gcd64(am, bm)) * bm;
               r = reduce(1'b0, l, 64'd1, ord);
            end else begin
               r = reduce(sgn, am * bm, 64'(ad * bd), ord);
            end
         end
      endcase
      return r;
   endfunction

   function void note_request(rau_pkg::req_type q);
      awaited.push_back(predict(q));
   endfunction

   function void check_result(rau_pkg::rsp_type got);
      rau_pkg::rsp_type want;
      checked++;
      if (awaited.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
         return;
      end
      want = awaited.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
          got.order !== want.order || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR: result num %0d den %0d ord %0d st %0d, expected %0d %0d %0d %0d",
                     got.res_num, got.res_den, got.order, got.status,
                     want.res_num, want.res_den, want.order, want.status);
      end
   endfunction
endclass

module testbench;
   import rau_pkg::*;

   localparam int LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rau_scoreboard board = new();
   int unsigned   sent;
   int unsigned   idle_cycles;
   bit            timed_out;

   rational_arithmetic_unit u_top (.*);

   always #6 clock = ~clock;

   function automatic int unsigned gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 400);
      return $urandom_range(0, 4);
   endfunction

   // Pick a numerator, biased to small values and extremes
   function automatic logic [31:0] pick_num();
      case ($urandom_range(0, 7))
         0: return 32'($urandom_range(0, 20)) * ($urandom_range(0, 1) ? -1 : 1);
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000001;
         2: return 32'h80000000;
         3, 4: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [30:0] pick_den();
      case ($urandom_range(0, 7))
         0, 1: return 31'd1;
         2: return 31'h7fffffff;
         3: return 31'd0;
         4, 5: return 31'($urandom_range(1, 1000));
         default: return 31'($urandom());
      endcase
   endfunction

   // Reduce to lowest terms so most items are well-formed
   function automatic req_type pick_request();
      req_type     q;
      logic [63:0] g;
      q.command = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
      q.a_num = pick_num();
      q.a_den = pick_den();
      q.b_num = pick_num();
      q.b_den = pick_den();
      if ($urandom_range(0, 4) != 0) begin
         if (q.a_den == 0) q.a_den = 31'd1;
         if (q.b_den == 0) q.b_den = 31'd1;
         if (q.a_num != 32'h80000000) begin
            g = board.gcd64(board.magnitude(longint'(q.a_num)), 64'(q.a_den));
            q.a_num = 32'(longint'(q.a_num) / longint'(g));
            q.a_den = 31'(64'(q.a_den) / g);
         end
         if (q.b_num != 32'h80000000) begin
            g = board.gcd64(board.magnitude(longint'(q.b_num)), 64'(q.b_den));
            q.b_num = 32'(longint'(q.b_num) / longint'(g));
            q.b_den = 31'(64'(q.b_den) / g);
         end
      end
      return q;
   endfunction

   // Hold the request until it transfers; drop valid only over a gap
   task automatic send(req_type q);
      int unsigned gap;
      gap = gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request(q);
      sent++;
   endtask

   task automatic directed(logic [2:0] c, logic [31:0] an, logic [30:0] ad,
                           logic [31:0] bn, logic [30:0] bd);
      req_type q;
      q.command = c;
      q.a_num = an;
      q.a_den = ad;
      q.b_num = bn;
      q.b_den = bd;
      send(q);
   endtask

   // Stall the result channel at random, with quiet stretches
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 99) < 40) rsp_stall <= $urandom_range(0, 2) == 0;
   end

   // Check each transferred result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Watchdog on cycles without a transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: every command, extremes, zero cases
      for (int c = 0; c < 6; c++)
         directed(3'(c), 32'd3, 31'd4, -32'd5, 31'd6);
      directed(CMD_DIV, 32'd7, 31'd2, 32'd0, 31'd1);
      directed(CMD_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
      directed(CMD_MUL, 32'h7fffffff, 31'd1, 32'h7fffffff, 31'd1);
      directed(CMD_MUL, 32'h80000000, 31'd1, -32'd1, 31'd1);
      directed(CMD_SUB, 32'h80000001, 31'h7fffffff, 32'h7fffffff, 31'h7ffffffe);
      directed(CMD_GCD, 32'd0, 31'd1, 32'd0, 31'd1);
      directed(CMD_GCD, -32'd12, 31'd1, 32'd18, 31'd1);
      directed(CMD_LCM, 32'd0, 31'd1, 32'd9, 31'd1);
      directed(CMD_LCM, 32'h7fffffff, 31'd1, 32'h7ffffffe, 31'd1);
      directed(CMD_LCM, 32'd2, 31'd3, -32'd3, 31'd4);
      directed(CMD_SUB, 32'd5, 31'd7, 32'd5, 31'd7);
      directed(CMD_ADD, 32'd2, 31'd4, 32'd3, 31'd9);
      directed(3'd6, 32'd1, 31'd2, 32'd3, 31'd4);
      directed(3'd7, -32'd1, 31'h7fffffff, 32'hffffffff, 31'h55555555);
      directed(CMD_DIV, 32'h7fffffff, 31'h7fffffff, 32'h1, 31'h7fffffff);
      for (int i = 0; i < 1630; i++) send(pick_request());
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      $display("Covered %0d requests over all commands, %0d results checked.",
               sent, board.checked);
      if (board.mismatches == 0 && board.awaited.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

/* filelist.f */
hdl/rau_pkg.sv
hdl/rau_gcd.sv
hdl/rau_div.sv
hdl/rau_mul.sv
hdl/rational_arithmetic_unit.sv
dv/testbench.sv
